/* src/postfix_expression_evaluator_core_assert.svh */
// Assertion macros shared by the checker.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_CORE_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define PEE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pee assertion failed");

// Next-cycle implication, disabled during reset
`define PEE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pee assertion failed");

`endif

/* src/pee_pkg.sv */
`timescale 1ns / 1ps

package pee_pkg;

    // ASCII codes of the accepted characters
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_9   = 8'h39;
    localparam logic [7:0] CH_ADD = 8'h2B;
    localparam logic [7:0] CH_SUB = 8'h2D;
    localparam logic [7:0] CH_MUL = 8'h2A;
    localparam logic [7:0] CH_DIV = 8'h2F;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_DIVZERO   = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    // Jump conditions of the sequencer
    typedef enum logic [3:0] {
        C_NONE,
        C_ALWAYS,
        C_NO_ACCEPT,
        C_NOT_DIGIT,
        C_NOT_OP,
        C_SP_GE2,
        C_IS_DIV,
        C_RIGHT_NZ,
        C_DIV_BUSY,
        C_NOT_LAST,
        C_OUT_FREE
    } cond_t;

    typedef logic [4:0] upc_t;

    // Microprogram addresses
    localparam upc_t U_IDLE   = 5'd0;
    localparam upc_t U_DISP   = 5'd1;
    localparam upc_t U_DIGIT  = 5'd2;
    localparam upc_t U_OPCLS  = 5'd3;
    localparam upc_t U_OPCHK  = 5'd4;
    localparam upc_t U_UFLOW  = 5'd5;
    localparam upc_t U_RD1    = 5'd6;
    localparam upc_t U_RD2    = 5'd7;
    localparam upc_t U_CAPL   = 5'd8;
    localparam upc_t U_ALU    = 5'd9;
    localparam upc_t U_DZCHK  = 5'd10;
    localparam upc_t U_DZ     = 5'd11;
    localparam upc_t U_DSTART = 5'd12;
    localparam upc_t U_DWAIT  = 5'd13;
    localparam upc_t U_DWR    = 5'd14;
    localparam upc_t U_END    = 5'd15;
    localparam upc_t U_ENDRD  = 5'd16;
    localparam upc_t U_EMIT   = 5'd17;
    localparam upc_t U_EWAIT  = 5'd18;

    // One control word per step
    typedef struct packed {
        logic  in_rdy;
        logic  rd_top;
        logic  rd_left;
        logic  cap_right;
        logic  cap_left;
        logic  push;
        logic  wr_alu;
        logic  wr_div;
        logic  div_start;
        logic  flag_uf;
        logic  flag_dz;
        logic  emit;
        cond_t cond;
        upc_t  target;
    } ctrl_t;

    // Control store: jump to target when cond holds, else step on
    function automatic ctrl_t ucode(input upc_t a);
        ctrl_t c;
        c = '0;
        c.cond = C_NONE;
        c.target = U_IDLE;
        unique case (a)
            U_IDLE:
            begin
                c.in_rdy = 1'b1;
                c.cond = C_NO_ACCEPT;
                c.target = U_IDLE;
            end
            U_DISP:
            begin
                c.cond = C_NOT_DIGIT;
                c.target = U_OPCLS;
            end
            U_DIGIT:
            begin
                c.push = 1'b1;
                c.cond = C_ALWAYS;
                c.target = U_END;
            end
            U_OPCLS:
            begin
                c.cond = C_NOT_OP;
                c.target = U_END;
            end
            U_OPCHK:
            begin
                c.cond = C_SP_GE2;
                c.target = U_RD1;
            end
            U_UFLOW:
            begin
                c.flag_uf = 1'b1;
                c.cond = C_ALWAYS;
                c.target = U_END;
            end
            U_RD1:
            begin
                c.rd_top = 1'b1;
            end
            U_RD2:
            begin
                c.cap_right = 1'b1;
                c.rd_left = 1'b1;
            end
            U_CAPL:
            begin
                c.cap_left = 1'b1;
                c.cond = C_IS_DIV;
                c.target = U_DZCHK;
            end
            U_ALU:
            begin
                c.wr_alu = 1'b1;
                c.cond = C_ALWAYS;
                c.target = U_END;
            end
            U_DZCHK:
            begin
                c.cond = C_RIGHT_NZ;
                c.target = U_DSTART;
            end
            U_DZ:
            begin
                c.flag_dz = 1'b1;
                c.cond = C_ALWAYS;
                c.target = U_END;
            end
            U_DSTART:
            begin
                c.div_start = 1'b1;
            end
            U_DWAIT:
            begin
                c.cond = C_DIV_BUSY;
                c.target = U_DWAIT;
            end
            U_DWR:
            begin
                c.wr_div = 1'b1;
            end
            U_END:
            begin
                c.cond = C_NOT_LAST;
                c.target = U_IDLE;
            end
            U_ENDRD:
            begin
                c.rd_top = 1'b1;
            end
            U_EMIT:
            begin
                c.emit = 1'b1;
                c.cond = C_OUT_FREE;
                c.target = U_IDLE;
            end
            U_EWAIT:
            begin
                c.cond = C_ALWAYS;
                c.target = U_EMIT;
            end
            default:
            begin
                c.cond = C_ALWAYS;
                c.target = U_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

/* src/pee_if.sv */
`timescale 1ns / 1ps

// Character channel
interface pee_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       end_of_expr;

    modport source (output valid, output symbol, output end_of_expr, input ready);
    modport sink (input valid, input symbol, input end_of_expr, output ready);
endinterface

// Result channel
interface pee_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic        [2:0]  status;

    modport source (output valid, output value, output status, input ready);
    modport sink (input valid, input value, input status, output ready);
endinterface

/* src/pee_ram.sv */
`timescale 1ns / 1ps

module pee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/pee_div.sv */
`timescale 1ns / 1ps

module pee_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        busy,
    output logic [31:0] quot
);

    logic [5:0]  count_reg, count_next;
    logic [31:0] q_reg, q_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dmag_reg, dmag_next;
    logic        neg_reg, neg_next;
    logic [32:0] trial;
    logic [32:0] diff;

    // Restoring division on magnitudes, one quotient bit per cycle
    always_comb
    begin
        count_next = count_reg;
        q_next = q_reg;
        rem_next = rem_reg;
        dmag_next = dmag_reg;
        neg_next = neg_reg;
        trial = {rem_reg, q_reg[31]};
        diff = trial - {1'b0, dmag_reg};
        if (start)
        begin
            count_next = 6'd32;
            q_next = num[31] ? (32'd0 - num) : num;
            dmag_next = den[31] ? (32'd0 - den) : den;
            rem_next = '0;
            neg_next = num[31] ^ den[31];
        end
        else if (count_reg != 6'd0)
        begin
            count_next = count_reg - 6'd1;
            if (!diff[32])
            begin
                rem_next = diff[31:0];
                q_next = {q_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial[31:0];
                q_next = {q_reg[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        rem_reg <= rem_next;
        dmag_reg <= dmag_next;
        neg_reg <= neg_next;
    end

    assign busy = (count_reg != 6'd0);
    assign quot = neg_reg ? (32'd0 - q_reg) : q_reg;

endmodule

/* src/postfix_expression_evaluator_core.sv */
`timescale 1ns / 1ps

// Channel  Dir  Payload                          Item
// expr     in   symbol[7:0], end_of_expr         one ASCII character
// result   out  value[31:0] signed, status[2:0]  one per expression end
//
// One character at a time: a digit is pushed, an ignored character is dropped,
// + - * read two operands and write the ALU result, / uses the bit-serial divider.
// The end flag adds a stack top read from the stack RAM and the result load.
// The result register lets the next character enter while a result waits;
// a second result stalls the sequencer until the first is taken.
// rst_n clears the step counter, stack pointer, error and result valid;
// the stack RAM needs no clearing.

module postfix_expression_evaluator_core #(
    parameter int STACK_DEPTH = 64
) (
    input logic       clk,
    input logic       rst_n,
    pee_in_if.sink    expr,
    pee_out_if.source result
);
    import pee_pkg::*;

    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    ctrl_t cw;
    upc_t upc_reg, upc_next;
    logic jump;
    logic accept;
    logic out_free;

    logic [7:0]      sym_reg;
    logic            last_reg;
    logic [31:0]     right_reg;
    logic [31:0]     left_reg;
    logic [SP_W-1:0] sp_reg, sp_next;
    status_t         err_reg, err_next;
    logic            out_valid_reg;
    logic [31:0]     value_reg;
    status_t         status_reg;

    logic [SP_W-1:0] sp_m1;
    logic [SP_W-1:0] sp_m2;
    logic            is_digit;
    logic            is_op;
    logic            full;
    logic [31:0]     alu_res;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [31:0]     ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [31:0]     ram_rdata;

    logic            div_busy;
    logic [31:0]     div_quot;

    assign cw = ucode(upc_reg);
    assign accept = cw.in_rdy && expr.valid;
    assign out_free = !out_valid_reg || result.ready;

    assign sp_m1 = sp_reg - SP_W'(1);
    assign sp_m2 = sp_reg - SP_W'(2);
    assign is_digit = (sym_reg >= CH_0) && (sym_reg <= CH_9);
    assign is_op = (sym_reg == CH_ADD) || (sym_reg == CH_SUB) ||
                   (sym_reg == CH_MUL) || (sym_reg == CH_DIV);
    assign full = (sp_reg == SP_W'(STACK_DEPTH));

    // Jump condition decode
    always_comb
    begin
        unique case (cw.cond)
            C_NONE:      jump = 1'b0;
            C_ALWAYS:    jump = 1'b1;
            C_NO_ACCEPT: jump = !accept;
            C_NOT_DIGIT: jump = !is_digit;
            C_NOT_OP:    jump = !is_op;
            C_SP_GE2:    jump = (sp_reg >= SP_W'(2));
            C_IS_DIV:    jump = (sym_reg == CH_DIV);
            C_RIGHT_NZ:  jump = (right_reg != 32'd0);
            C_DIV_BUSY:  jump = div_busy;
            C_NOT_LAST:  jump = !last_reg;
            C_OUT_FREE:  jump = out_free;
            default:     jump = 1'b1;
        endcase
        upc_next = jump ? cw.target : (upc_reg + upc_t'(1));
    end

    // Add, subtract, multiply (low 32 bits are the same signed or not)
    always_comb
    begin
        case (sym_reg)
            CH_ADD:  alu_res = left_reg + right_reg;
            CH_SUB:  alu_res = left_reg - right_reg;
            default: alu_res = left_reg * right_reg;
        endcase
    end

    // Stack RAM ports
    always_comb
    begin
        ram_we = 1'b0;
        ram_waddr = sp_m2[AW-1:0];
        ram_wdata = alu_res;
        if (cw.push)
        begin
            ram_we = !full;
            ram_waddr = sp_reg[AW-1:0];
            ram_wdata = {24'd0, sym_reg - CH_0};
        end
        else if (cw.wr_alu)
        begin
            ram_we = 1'b1;
        end
        else if (cw.wr_div)
        begin
            ram_we = 1'b1;
            ram_wdata = div_quot;
        end
        ram_re = cw.rd_top || cw.rd_left;
        ram_raddr = cw.rd_left ? sp_m2[AW-1:0] : sp_m1[AW-1:0];
    end

    // Stack pointer and sticky error
    always_comb
    begin
        sp_next = sp_reg;
        err_next = err_reg;
        if (cw.push)
        begin
            if (full)
            begin
                if (err_reg == ST_OK)
                begin
                    err_next = ST_FULL;
                end
            end
            else
            begin
                sp_next = sp_reg + SP_W'(1);
            end
        end
        if (cw.wr_alu || cw.wr_div)
        begin
            sp_next = sp_m1;
        end
        if (cw.flag_uf && (err_reg == ST_OK))
        begin
            err_next = ST_UNDERFLOW;
        end
        if (cw.flag_dz && (err_reg == ST_OK))
        begin
            err_next = ST_DIVZERO;
        end
        if (cw.emit && out_free)
        begin
            sp_next = '0;
            err_next = ST_OK;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= U_IDLE;
            sp_reg <= '0;
            err_reg <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg <= upc_next;
            sp_reg <= sp_next;
            err_reg <= err_next;
            if (cw.emit && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Operand and result registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sym_reg <= expr.symbol;
            last_reg <= expr.end_of_expr;
        end
        if (cw.cap_right)
        begin
            right_reg <= ram_rdata;
        end
        if (cw.cap_left)
        begin
            left_reg <= ram_rdata;
        end
        if (cw.emit && out_free)
        begin
            if (sp_reg == '0)
            begin
                value_reg <= '0;
                status_reg <= (err_reg != ST_OK) ? err_reg : ST_EMPTY;
            end
            else
            begin
                value_reg <= ram_rdata;
                status_reg <= err_reg;
            end
        end
    end

    pee_ram #(
        .WIDTH(32),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    pee_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(cw.div_start),
        .num  (left_reg),
        .den  (right_reg),
        .busy (div_busy),
        .quot (div_quot)
    );

    assign expr.ready = cw.in_rdy;
    assign result.valid = out_valid_reg;
    assign result.value = value_reg;
    assign result.status = status_reg;

endmodule

/* src/pee_checker.sv */
`timescale 1ns / 1ps
`include "postfix_expression_evaluator_core_assert.svh"

module pee_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        expr_valid,
    input logic        expr_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [31:0] res_value,
    input logic [2:0]  res_status
);
    import pee_pkg::*;

    // A waiting result holds its payload
    `PEE_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_value) && $stable(res_status))

    // One character at a time: no new character right after one is taken
    `PEE_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, expr_valid && expr_ready, !expr_ready)

    // A result never shows up the cycle after a character is taken
    `PEE_ASSERT_NEXT(a_no_instant_res, clk, rst_n, expr_valid && expr_ready && !res_valid, !res_valid)

    // An empty stack at the end reports zero
    `PEE_ASSERT_IMP(a_empty_zero, clk, rst_n, res_valid && (res_status == ST_EMPTY), res_value == 32'd0)

endmodule

bind postfix_expression_evaluator_core pee_checker u_pee_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .expr_valid(expr.valid),
    .expr_ready(expr.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_value (result.value),
    .res_status(result.status)
);
